// ===== design/bst_pkg.sv =====
`default_nettype none
package bst_pkg;
	// result kinds
	localparam logic KIND_INDEX = 1'b0;
	localparam logic KIND_BYTE  = 1'b1;

	// controller commands to the datapath
	typedef struct packed {
		logic store;      // write input byte at fill position
		logic clr_fill;   // block done: fill count, overflow, i and primary index back to zero
		logic ins_init;   // start insertion of rotation i: j=i
		logic cmp_init;   // start compare of rotation i vs sorted[j-1]
		logic cmp_step;   // advance compare by one byte
		logic shift;      // sorted[j] = sorted[j-1], j--
		logic place;      // sorted[j] = i, i++
		logic rd_sorted;  // read sorted[k]
		logic rd_byte;    // read block byte before registered start
		logic k_clr;
		logic k_inc;
		logic pos_chk;    // compare sorted start with target
	} bst_cmd_t;

	typedef struct packed {
		logic i_done;     // i == n
		logic j_zero;
		logic cmp_less;   // compare finished: rotation i < sorted[j-1]
		logic cmp_done;   // compare finished (any result)
		logic k_last;     // k == n-1
	} bst_sts_t;
endpackage
`default_nettype wire

// ===== design/bst_ram.sv =====
`default_nettype none
module bst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 63
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== design/bst_datapath.sv =====
`default_nettype none
module bst_datapath #(
	parameter int BLOCK_MAX = 63
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire bst_pkg::bst_cmd_t cmd,
	output bst_pkg::bst_sts_t      sts,
	input  wire logic [7:0]        in_byte,
	output logic [7:0]             byte_out,
	output logic [7:0]             pos_out,
	output logic                   ovf_out
);
	import bst_pkg::*;

	localparam int AW = $clog2(BLOCK_MAX + 1);

	logic [AW-1:0] fill_q, i_q, j_q, k_q, pos_q, pa_q, pb_q, cnt_q;
	logic          ovf_q;
	logic [AW-1:0] n;

	// two block ports needed in a compare step: two RAM copies
	logic          bwe;
	logic [AW-1:0] bwa, bra, brb;
	logic [7:0]    bda, bdb;
	logic          swe;
	logic [AW-1:0] swa, sra, swd;
	logic [AW-1:0] sdo;

	assign n = fill_q;

	// pointer after wrap
	function automatic logic [AW-1:0] nxt(input logic [AW-1:0] p, input logic [AW-1:0] m);
		nxt = (p + AW'(1) >= m) ? '0 : p + AW'(1);
	endfunction

	assign bwe = cmd.store && (fill_q < AW'(BLOCK_MAX));
	assign bwa = fill_q;

	// block read addresses: compare pointers, or byte before the sorted start
	always_comb begin
		bra = pa_q;
		brb = pb_q;
		if (cmd.rd_byte) bra = (sdo == '0) ? n - AW'(1) : sdo - AW'(1);
		if (cmd.cmp_init) begin
			bra = i_q;
			brb = sdo;
		end else if (cmd.cmp_step) begin
			bra = nxt(pa_q, n);
			brb = nxt(pb_q, n);
		end
	end

	bst_ram #(.WIDTH(8), .DEPTH(BLOCK_MAX)) u_blk_a (.clk(clk), .we(bwe),
		.waddr(bwa[$clog2(BLOCK_MAX)-1:0]), .wdata(in_byte),
		.raddr(bra[$clog2(BLOCK_MAX)-1:0]), .rdata(bda));
	bst_ram #(.WIDTH(8), .DEPTH(BLOCK_MAX)) u_blk_b (.clk(clk), .we(bwe),
		.waddr(bwa[$clog2(BLOCK_MAX)-1:0]), .wdata(in_byte),
		.raddr(brb[$clog2(BLOCK_MAX)-1:0]), .rdata(bdb));

	// sorted-start store: one read address, one write
	always_comb begin
		swe = cmd.shift || cmd.place;
		swa = j_q;
		swd = cmd.shift ? sdo : i_q;
		sra = cmd.rd_sorted ? k_q : j_q - AW'(1);
		if (cmd.shift) sra = j_q - AW'(2);
	end

	bst_ram #(.WIDTH(AW), .DEPTH(BLOCK_MAX)) u_srt (.clk(clk), .we(swe),
		.waddr(swa[$clog2(BLOCK_MAX)-1:0]), .wdata(swd),
		.raddr(sra[$clog2(BLOCK_MAX)-1:0]), .rdata(sdo));

	// compare status: data of current step is in bda/bdb
	assign sts.i_done    = i_q == n;
	assign sts.j_zero    = j_q == '0;
	assign sts.cmp_done  = (bda != bdb) || (cnt_q + AW'(1) >= n);
	assign sts.cmp_less  = bda < bdb;
	assign sts.k_last    = k_q == n - AW'(1);

	assign byte_out = bda;
	assign pos_out  = 8'((pos_q == '0) ? AW'(1) : pos_q);
	assign ovf_out  = ovf_q;

	// counters and pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0; ovf_q <= 1'b0; i_q <= '0; j_q <= '0; k_q <= '0;
			pos_q <= '0; pa_q <= '0; pb_q <= '0; cnt_q <= '0;
		end else begin
			if (cmd.store) begin
				if (fill_q < AW'(BLOCK_MAX)) fill_q <= fill_q + AW'(1);
				else ovf_q <= 1'b1;
			end
			if (cmd.clr_fill) begin
				fill_q <= '0; ovf_q <= 1'b0; i_q <= '0; pos_q <= '0;
			end
			if (cmd.ins_init) j_q <= i_q;
			if (cmd.cmp_init) begin
				pa_q <= i_q; pb_q <= sdo; cnt_q <= '0;
			end
			if (cmd.cmp_step) begin
				pa_q <= nxt(pa_q, n); pb_q <= nxt(pb_q, n); cnt_q <= cnt_q + AW'(1);
			end
			if (cmd.shift) j_q <= j_q - AW'(1);
			if (cmd.place) i_q <= i_q + AW'(1);
			if (cmd.k_clr) k_q <= '0;
			if (cmd.k_inc) k_q <= k_q + AW'(1);
			// primary index: first match of target
			if (cmd.pos_chk && sdo == ((n > AW'(1)) ? AW'(1) : AW'(0)) && pos_q == '0)
				pos_q <= k_q;
		end
	end
endmodule
`default_nettype wire

// ===== design/bst_ctrl.sv =====
`default_nettype none
module bst_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic              s_tlast,
	input  wire bst_pkg::bst_sts_t sts,
	output bst_pkg::bst_cmd_t      cmd,
	output logic                   emit_idx,
	output logic                   emit_byte,
	output logic                   emit_last,
	input  wire logic              out_free
);
	import bst_pkg::*;

	localparam logic [3:0] ST_LOAD  = 4'd0;
	localparam logic [3:0] ST_INS   = 4'd1;
	localparam logic [3:0] ST_RDJ   = 4'd2;
	localparam logic [3:0] ST_CINIT = 4'd3;
	localparam logic [3:0] ST_CMP   = 4'd4;
	localparam logic [3:0] ST_POSR  = 4'd5;
	localparam logic [3:0] ST_POSC  = 4'd6;
	localparam logic [3:0] ST_PIDX  = 4'd7;
	localparam logic [3:0] ST_ORD   = 4'd8;
	localparam logic [3:0] ST_OBR   = 4'd9;
	localparam logic [3:0] ST_OEMIT = 4'd10;
	localparam logic [3:0] ST_SHW   = 4'd11;

	logic [3:0] state_q, state_d;

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		s_tready  = 1'b0;
		emit_idx  = 1'b0;
		emit_byte = 1'b0;
		emit_last = 1'b0;
		case (state_q)
			ST_LOAD: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.store = 1'b1;
					if (s_tlast) state_d = ST_INS;
				end
			end
			// insertion sort, one rotation at a time
			ST_INS: begin
				if (sts.i_done) begin
					cmd.k_clr = 1'b1;
					state_d = ST_POSR;
				end else begin
					cmd.ins_init = 1'b1;
					state_d = ST_RDJ;
				end
			end
			ST_RDJ: begin
				if (sts.j_zero) begin
					cmd.place = 1'b1;
					state_d = ST_INS;
				end else state_d = ST_CINIT;
			end
			ST_CINIT: begin
				cmd.cmp_init = 1'b1;
				state_d = ST_CMP;
			end
			ST_CMP: begin
				if (sts.cmp_done) begin
					if (sts.cmp_less) begin
						cmd.shift = 1'b1;
						state_d = ST_SHW;
					end else begin
						cmd.place = 1'b1;
						state_d = ST_INS;
					end
				end else cmd.cmp_step = 1'b1;
			end
			// shift done; sorted[j-1] for new j is read now
			ST_SHW: state_d = ST_RDJ;
			// search primary index
			ST_POSR: begin
				cmd.rd_sorted = 1'b1;
				state_d = ST_POSC;
			end
			ST_POSC: begin
				cmd.pos_chk = 1'b1;
				if (sts.k_last) state_d = ST_PIDX;
				else begin
					cmd.k_inc = 1'b1;
					state_d = ST_POSR;
				end
			end
			ST_PIDX: begin
				if (out_free) begin
					emit_idx = 1'b1;
					cmd.k_clr = 1'b1;
					state_d = ST_ORD;
				end
			end
			ST_ORD: begin
				cmd.rd_sorted = 1'b1;
				state_d = ST_OBR;
			end
			ST_OBR: begin
				cmd.rd_sorted = 1'b1;
				cmd.rd_byte = 1'b1;
				state_d = ST_OEMIT;
			end
			// keep both reads on the same address while the output waits
			ST_OEMIT: begin
				cmd.rd_sorted = 1'b1;
				cmd.rd_byte = 1'b1;
				if (out_free) begin
					emit_byte = 1'b1;
					emit_last = sts.k_last;
					if (sts.k_last) begin
						cmd.clr_fill = 1'b1;
						state_d = ST_LOAD;
					end else begin
						cmd.k_inc = 1'b1;
						state_d = ST_ORD;
					end
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_LOAD;
		else state_q <= state_d;
	end
endmodule
`default_nettype wire

// ===== design/block_sorting_transform.sv =====
// Block sorting transform: loads up to BLOCK_MAX bytes (one per cycle), then
// sorts rotations by insertion sort with a byte-serial compare (one byte per
// cycle over two block RAM ports), then searches the primary index. Output:
// primary index, then N bytes; the next block is accepted after the last result.
// Reset (arst_n low) returns to loading with an empty block; RAM is not cleared.
`default_nettype none
module block_sorting_transform #(
	parameter int BLOCK_MAX = 63
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,  // [7:0] data_byte
	input  wire logic        s_tlast,  // block_end
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,  // [7:0] item_value
	output logic [1:0]       m_tuser,  // [0] item_kind, [1] overflow
	output logic             m_tlast   // run_end
);
	import bst_pkg::*;

	bst_cmd_t   cmd;
	bst_sts_t   sts;
	logic [7:0] byte_out, pos_out;
	logic       ovf_out, emit_idx, emit_byte, emit_last, out_free;

	logic       vld_q, kind_q, ovf_q, last_q;
	logic [7:0] val_q;

	assign out_free = !vld_q || m_tready;

	bst_ctrl u_ctrl (.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.s_tlast(s_tlast), .sts(sts), .cmd(cmd), .emit_idx(emit_idx),
		.emit_byte(emit_byte), .emit_last(emit_last), .out_free(out_free));

	bst_datapath #(.BLOCK_MAX(BLOCK_MAX)) u_dp (.clk(clk), .arst_n(arst_n), .cmd(cmd),
		.sts(sts), .in_byte(s_tdata), .byte_out(byte_out), .pos_out(pos_out),
		.ovf_out(ovf_out));

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= 1'b0;
		else if (emit_idx || emit_byte) vld_q <= 1'b1;
		else if (m_tready) vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit_idx || emit_byte) begin
			kind_q <= emit_byte ? KIND_BYTE : KIND_INDEX;
			val_q  <= emit_byte ? byte_out : pos_out;
			ovf_q  <= ovf_out;
			last_q <= emit_last;
		end
	end

	assign m_tvalid = vld_q;
	assign m_tdata  = val_q;
	assign m_tuser  = {ovf_q, kind_q};
	assign m_tlast  = last_q;

	// no new result may overwrite one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !(emit_idx || emit_byte))
		else $error("result overwritten");
	// no input accepted while results are produced
	a_no_load_while_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_idx || emit_byte) |-> !s_tready)
		else $error("input accepted during output");
	// a last result is a transformed byte
	a_last_is_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (m_tuser[0] == KIND_BYTE))
		else $error("run end on index");
endmodule
`default_nettype wire
